/* hdl/pvqs_pkg.sv */
// pvqs_pkg: shared types, codes and constants of the vehicle queue signal block
// depends on nothing; imported by every module of the block

package pvqs_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 64;

  localparam int ID_W     = 16;
  localparam int THR_W    = 7;
  localparam int GREEN_W  = 8;
  localparam int WAIT_W   = 7;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int COUNT_W  = 5;   // green / 10 is at most 25

  // reciprocal of ten for an 8 bit value: (x * 205) >> 11
  localparam int RECIP_TEN   = 205;
  localparam int RECIP_SHIFT = 11;
  localparam int PROD_W      = GREEN_W + 8;

  localparam logic [THR_W-1:0]   RST_HIGH_THR   = THR_W'(10);
  localparam logic [THR_W-1:0]   RST_MID_THR    = THR_W'(5);
  localparam logic [GREEN_W-1:0] RST_GREEN_LONG  = GREEN_W'(60);
  localparam logic [GREEN_W-1:0] RST_GREEN_MID   = GREEN_W'(40);
  localparam logic [GREEN_W-1:0] RST_GREEN_SHORT = GREEN_W'(20);

  typedef enum logic [2:0] {
    ST_PASSED   = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_DONE     = 3'd2,
    ST_ACCEPTED = 3'd3,
    ST_DROPPED  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGH_THR    = 3'd0,
    CFG_MID_THR     = 3'd1,
    CFG_GREEN_LONG  = 3'd2,
    CFG_GREEN_MID   = 3'd3,
    CFG_GREEN_SHORT = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    CMD_ARRIVAL = 1'b0,
    CMD_SIGNAL  = 1'b1
  } command_t;

  typedef struct packed {
    command_t          command;
    logic [ID_W-1:0]   vehicle_id;
    logic              emergency;
  } item_t;

  typedef struct packed {
    status_t             status;
    logic [ID_W-1:0]     released_id;
    logic                released_emergency;
    logic [GREEN_W-1:0]  green_seconds;
    logic [WAIT_W-1:0]   waiting_count;
    logic                last;
  } result_t;

  typedef struct packed {
    logic            emergency;
    logic [ID_W-1:0] id;
  } slot_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARRIVE,
    S_GREEN,
    S_COUNT,
    S_POP,
    S_PASS
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic arrive;
    logic sel_green;
    logic calc_count;
    logic pop;
    logic emit_pass;
    logic emit_done;
    logic emit_empty;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic occ_zero;
    logic count_zero;
  } dp_status_t;

endpackage

/* hdl/pvqs_ctrl.sv */
// pvqs_ctrl: sequencer for arrivals and signal events
// depends on pvqs_pkg; drives pvqs_dpath through ctrl_cmd_t

module pvqs_ctrl
  import pvqs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  command_t   command,
  input  dp_status_t stat,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = (command == CMD_SIGNAL) ? S_GREEN : S_ARRIVE;
        end
      end
      S_ARRIVE: begin
        cmd.arrive = 1'b1;
        state_next = S_IDLE;
      end
      S_GREEN: begin
        if (stat.occ_zero) begin
          cmd.emit_empty = 1'b1;
          state_next     = S_IDLE;
        end else begin
          cmd.sel_green = 1'b1;
          state_next    = S_COUNT;
        end
      end
      S_COUNT: begin
        cmd.calc_count = 1'b1;
        state_next     = S_POP;
      end
      S_POP: begin
        // stop when the green budget or the queue runs out
        if (stat.count_zero || stat.occ_zero) begin
          cmd.emit_done = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.pop    = 1'b1;
          state_next = S_PASS;
        end
      end
      S_PASS: begin
        cmd.emit_pass = 1'b1;
        state_next    = S_POP;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

/* hdl/pvqs_dpath.sv */
// pvqs_dpath: slot ring, pointers, occupancy, config registers and result register
// depends on pvqs_pkg; commanded by pvqs_ctrl

module pvqs_dpath
  import pvqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            cmd,
  output dp_status_t           stat,
  input  item_t                item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 strobe,
  output result_t              result
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (OCC_W > THR_W) ? OCC_W : THR_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

  slot_t mem [QUEUE_DEPTH];
  slot_t rd_data;

  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   tail;
  logic [OCC_W-1:0]   occ;
  logic [COUNT_W-1:0] count;
  logic [GREEN_W-1:0] green;
  item_t              held;

  logic [THR_W-1:0]   high_thr;
  logic [THR_W-1:0]   mid_thr;
  logic [GREEN_W-1:0] green_long;
  logic [GREEN_W-1:0] green_mid;
  logic [GREEN_W-1:0] green_short;

  logic [PTR_W-1:0]   head_inc;
  logic [PTR_W-1:0]   head_dec;
  logic [PTR_W-1:0]   tail_inc;
  logic               full;
  logic [GREEN_W-1:0] green_sel;
  logic [PROD_W-1:0]  prod;
  logic [OCC_W-1:0]   occ_inc;

  assign head_inc = (head == PTR_LAST) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? PTR_LAST : head - 1'b1;
  assign tail_inc = (tail == PTR_LAST) ? '0 : tail + 1'b1;
  assign full     = (occ == OCC_FULL);
  assign occ_inc  = occ + 1'b1;

  always_comb begin
    if (CMP_W'(occ) > CMP_W'(high_thr)) begin
      green_sel = green_long;
    end else if (CMP_W'(occ) > CMP_W'(mid_thr)) begin
      green_sel = green_mid;
    end else begin
      green_sel = green_short;
    end
  end

  // divide by ten through the reciprocal
  assign prod = PROD_W'(green) * PROD_W'(RECIP_TEN);

  assign stat.occ_zero   = (occ == '0);
  assign stat.count_zero = (count == '0);

  // slot ring
  always_ff @(posedge clk) begin
    if (cmd.arrive && !full) begin
      if (held.emergency) begin
        mem[head_dec] <= '{emergency: 1'b1, id: held.vehicle_id};
      end else begin
        mem[tail] <= '{emergency: 1'b0, id: held.vehicle_id};
      end
    end
    if (cmd.pop) begin
      rd_data <= mem[head];
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      high_thr    <= RST_HIGH_THR;
      mid_thr     <= RST_MID_THR;
      green_long  <= RST_GREEN_LONG;
      green_mid   <= RST_GREEN_MID;
      green_short <= RST_GREEN_SHORT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HIGH_THR:    high_thr    <= cfg_data[THR_W-1:0];
        CFG_MID_THR:     mid_thr     <= cfg_data[THR_W-1:0];
        CFG_GREEN_LONG:  green_long  <= cfg_data;
        CFG_GREEN_MID:   green_mid   <= cfg_data;
        CFG_GREEN_SHORT: green_short <= cfg_data;
        default: ;
      endcase
    end
  end

  // queue control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      occ  <= '0;
    end else if (cmd.arrive && !full) begin
      occ <= occ_inc;
      if (held.emergency) begin
        head <= head_dec;
      end else begin
        tail <= tail_inc;
      end
    end else if (cmd.pop) begin
      head <= head_inc;
      occ  <= occ - 1'b1;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      held <= item;
    end
    if (cmd.sel_green) begin
      green <= green_sel;
    end
    if (cmd.calc_count) begin
      count <= prod[RECIP_SHIFT +: COUNT_W];
    end else if (cmd.pop) begin
      count <= count - 1'b1;
    end
  end

  // result register, one transfer per strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.arrive | cmd.emit_pass | cmd.emit_done | cmd.emit_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.arrive) begin
      result.status             <= full ? ST_DROPPED : ST_ACCEPTED;
      result.released_id        <= '0;
      result.released_emergency <= 1'b0;
      result.green_seconds      <= '0;
      result.waiting_count      <= full ? WAIT_W'(occ) : WAIT_W'(occ_inc);
      result.last               <= 1'b1;
    end else if (cmd.emit_pass) begin
      result.status             <= ST_PASSED;
      result.released_id        <= rd_data.id;
      result.released_emergency <= rd_data.emergency;
      result.green_seconds      <= green;
      result.waiting_count      <= WAIT_W'(occ);
      result.last               <= 1'b0;
    end else if (cmd.emit_done) begin
      result.status             <= ST_DONE;
      result.released_id        <= '0;
      result.released_emergency <= 1'b0;
      result.green_seconds      <= green;
      result.waiting_count      <= WAIT_W'(occ);
      result.last               <= 1'b1;
    end else if (cmd.emit_empty) begin
      result.status             <= ST_EMPTY;
      result.released_id        <= '0;
      result.released_emergency <= 1'b0;
      result.green_seconds      <= '0;
      result.waiting_count      <= '0;
      result.last               <= 1'b1;
    end
  end

endmodule

/* hdl/priority_vehicle_queue_signal.sv */
// priority_vehicle_queue_signal: top level of the vehicle queue with signal timing
// depends on pvqs_pkg, pvqs_ctrl and pvqs_dpath
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------
//   item in  | start, busy          | item   (item_t)
//   result   | strobe               | result (result_t)
//   config   | cfg_we               | cfg_index, cfg_data
//
// an arrival is accepted, then written into the ring; its result shows while
// the block is already idle again.
// a signal event reads each released vehicle from the ring, then emits its result,
// as the slot memory read is registered; on an empty queue it emits only the empty result.
// reset clears pointers, occupancy and config registers; slot contents are not cleared.
// results cannot be stalled: each is a one cycle strobe transfer.

module priority_vehicle_queue_signal
  import pvqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  item_t                item,
  output logic                 strobe,
  output result_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  pvqs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (item.command),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  pvqs_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .strobe    (strobe),
    .result    (result)
  );

endmodule

/* hdl/pvqs_checker.sv */
// pvqs_checker: port level checks of the vehicle queue signal block
// depends on pvqs_pkg; bound to priority_vehicle_queue_signal below

module pvqs_checker
  import pvqs_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input item_t   item,
  input logic    strobe,
  input result_t result
);

  // the final result of an item comes out once the block is free again
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |-> !busy)
    else $error("final result while busy");

  // passed vehicles always belong to a running signal event
  a_pass_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |-> busy && (result.status == ST_PASSED))
    else $error("non-final result outside a signal event");

  // a release needs at least ten green seconds
  a_pass_green: assert property (@(posedge clk) disable iff (rst)
    strobe && (result.status == ST_PASSED) |-> (result.green_seconds >= GREEN_W'(10)))
    else $error("vehicle released with short green");

  // an accepted item makes the block busy in the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item left the block idle");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !strobe)
    else $error("strobe right after reset");

endmodule

bind priority_vehicle_queue_signal pvqs_checker u_pvqs_checker (.*);

/* tb/tb_priority_vehicle_queue_signal.sv */
`timescale 1ns / 100ps
// tb_priority_vehicle_queue_signal: self-checking testbench of the vehicle queue signal block
// depends on pvqs_pkg and priority_vehicle_queue_signal; directed table, then random
// arrival bursts and signal events checked against a behavioral queue mirror

module tb_priority_vehicle_queue_signal;
  import pvqs_pkg::*;

  localparam int DEPTH         = DEFAULT_QUEUE_DEPTH;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int SEG_ITEMS     = 50;
  localparam int SEGMENTS      = 6;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } plan_row_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  item_t                item;
  logic                 strobe;
  result_t              result;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // queue mirror and its register copies
  slot_t              ring_mirror [DEPTH];
  int                 head_mirror;
  int                 tail_mirror;
  int                 occ_mirror;
  logic [THR_W-1:0]   thr_high;
  logic [THR_W-1:0]   thr_mid;
  logic [GREEN_W-1:0] grn_long;
  logic [GREEN_W-1:0] grn_mid;
  logic [GREEN_W-1:0] grn_short;

  result_t   pending_results [$];
  bit        use_typed;
  result_t   typed_want;
  int        errors;
  int        transfers_in;
  int        stall_cycles;
  int        idle_pct;
  plan_row_t directed_plan [25];

  priority_vehicle_queue_signal u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .strobe   (strobe),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void predict_transfer(item_t it);
    result_t            r;
    logic [GREEN_W-1:0] green;
    int                 allowed;
    r = '0;
    if (it.command == CMD_ARRIVAL) begin
      if (occ_mirror >= DEPTH) begin
        r.status = ST_DROPPED;
      end else begin
        if (it.emergency) begin
          head_mirror = (head_mirror + DEPTH - 1) % DEPTH;
          ring_mirror[head_mirror] = '{emergency: 1'b1, id: it.vehicle_id};
        end else begin
          ring_mirror[tail_mirror] = '{emergency: 1'b0, id: it.vehicle_id};
          tail_mirror = (tail_mirror + 1) % DEPTH;
        end
        occ_mirror++;
        r.status = ST_ACCEPTED;
      end
      r.waiting_count = WAIT_W'(occ_mirror);
      r.last = 1'b1;
      pending_results.push_back(r);
    end else if (occ_mirror == 0) begin
      r.status = ST_EMPTY;
      r.last = 1'b1;
      pending_results.push_back(r);
    end else begin
      if (occ_mirror > int'(thr_high)) begin
        green = grn_long;
      end else if (occ_mirror > int'(thr_mid)) begin
        green = grn_mid;
      end else begin
        green = grn_short;
      end
      allowed = int'(green) / 10;
      r.green_seconds = green;
      while (allowed > 0 && occ_mirror > 0) begin
        r.status = ST_PASSED;
        r.released_id = ring_mirror[head_mirror].id;
        r.released_emergency = ring_mirror[head_mirror].emergency;
        head_mirror = (head_mirror + 1) % DEPTH;
        occ_mirror--;
        allowed--;
        r.waiting_count = WAIT_W'(occ_mirror);
        pending_results.push_back(r);
      end
      r.status = ST_DONE;
      r.released_id = '0;
      r.released_emergency = 1'b0;
      r.waiting_count = WAIT_W'(occ_mirror);
      r.last = 1'b1;
      pending_results.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  // transfers in, results out, and the no-progress watchdog
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst) begin
      if (start && !busy) begin
        predict_transfer(item);
        if (use_typed) begin
          pending_results[pending_results.size() - 1] = typed_want;
        end
        transfers_in++;
      end
      if (strobe) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", 64'(result), 64'd0);
        end else begin
          want = pending_results.pop_front();
          if (result.status !== want.status)
            report_mismatch("status", 64'(result.status), 64'(want.status));
          if (result.released_id !== want.released_id)
            report_mismatch("released_id", 64'(result.released_id), 64'(want.released_id));
          if (result.released_emergency !== want.released_emergency)
            report_mismatch("released_emergency", 64'(result.released_emergency),
                            64'(want.released_emergency));
          if (result.green_seconds !== want.green_seconds)
            report_mismatch("green_seconds", 64'(result.green_seconds),
                            64'(want.green_seconds));
          if (result.waiting_count !== want.waiting_count)
            report_mismatch("waiting_count", 64'(result.waiting_count),
                            64'(want.waiting_count));
          if (result.last !== want.last)
            report_mismatch("last", 64'(result.last), 64'(want.last));
        end
      end
      if ((start && !busy) || strobe) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic item_t rand_item(command_t cmd);
    item_t it;
    it.command = cmd;
    it.vehicle_id = ID_W'($urandom);
    it.emergency = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer, start still high
  task automatic send_item(input item_t it, input bit typed, input result_t want);
    int taken;
    taken = transfers_in;
    item = it;
    use_typed = typed;
    typed_want = want;
    start = 1'b1;
    do @(negedge clk); while (transfers_in == taken);
  endtask

  task automatic idle_gap();
    if ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    case (idx)
      CFG_HIGH_THR:    thr_high = data[THR_W-1:0];
      CFG_MID_THR:     thr_mid = data[THR_W-1:0];
      CFG_GREEN_LONG:  grn_long = data;
      CFG_GREEN_MID:   grn_mid = data;
      CFG_GREEN_SHORT: grn_short = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    int      seg;
    int      sent;
    int      burst;
    result_t none;
    none = '0;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst = 1'b1;
    use_typed = 1'b0;
    typed_want = '0;
    errors = 0;
    transfers_in = 0;
    stall_cycles = 0;
    idle_pct = 16;
    head_mirror = 0;
    tail_mirror = 0;
    occ_mirror = 0;
    thr_high = RST_HIGH_THR;
    thr_mid = RST_MID_THR;
    grn_long = RST_GREEN_LONG;
    grn_mid = RST_GREEN_MID;
    grn_short = RST_GREEN_SHORT;

    // default thresholds: short, mid and long green all reached
    directed_plan = '{
      '{item_t'{CMD_SIGNAL, 16'h0000, 1'b0}, 1'b1,
        result_t'{ST_EMPTY, 16'd0, 1'b0, 8'd0, 7'd0, 1'b1}},
      '{item_t'{CMD_ARRIVAL, 16'hFFFF, 1'b0}, 1'b1,
        result_t'{ST_ACCEPTED, 16'd0, 1'b0, 8'd0, 7'd1, 1'b1}},
      '{item_t'{CMD_ARRIVAL, 16'h0000, 1'b1}, 1'b1,
        result_t'{ST_ACCEPTED, 16'd0, 1'b0, 8'd0, 7'd2, 1'b1}},
      '{item_t'{CMD_ARRIVAL, 16'h8001, 1'b1}, 1'b1,
        result_t'{ST_ACCEPTED, 16'd0, 1'b0, 8'd0, 7'd3, 1'b1}},
      '{item_t'{CMD_ARRIVAL, 16'h7FFE, 1'b0}, 1'b1,
        result_t'{ST_ACCEPTED, 16'd0, 1'b0, 8'd0, 7'd4, 1'b1}},
      '{item_t'{CMD_SIGNAL, 16'hFFFF, 1'b1}, 1'b0, '0},
      '{item_t'{CMD_SIGNAL, 16'h0000, 1'b0}, 1'b0, '0},
      '{item_t'{CMD_SIGNAL, 16'h5A5A, 1'b1}, 1'b1,
        result_t'{ST_EMPTY, 16'd0, 1'b0, 8'd0, 7'd0, 1'b1}},
      '{item_t'{CMD_ARRIVAL, 16'h0001, 1'b0}, 1'b1,
        result_t'{ST_ACCEPTED, 16'd0, 1'b0, 8'd0, 7'd1, 1'b1}},
      '{item_t'{CMD_ARRIVAL, 16'h0002, 1'b1}, 1'b1,
        result_t'{ST_ACCEPTED, 16'd0, 1'b0, 8'd0, 7'd2, 1'b1}},
      '{item_t'{CMD_ARRIVAL, 16'h0004, 1'b0}, 1'b1,
        result_t'{ST_ACCEPTED, 16'd0, 1'b0, 8'd0, 7'd3, 1'b1}},
      '{item_t'{CMD_ARRIVAL, 16'h0008, 1'b1}, 1'b1,
        result_t'{ST_ACCEPTED, 16'd0, 1'b0, 8'd0, 7'd4, 1'b1}},
      '{item_t'{CMD_ARRIVAL, 16'h0010, 1'b0}, 1'b1,
        result_t'{ST_ACCEPTED, 16'd0, 1'b0, 8'd0, 7'd5, 1'b1}},
      '{item_t'{CMD_ARRIVAL, 16'h0020, 1'b0}, 1'b1,
        result_t'{ST_ACCEPTED, 16'd0, 1'b0, 8'd0, 7'd6, 1'b1}},
      '{item_t'{CMD_ARRIVAL, 16'h0040, 1'b1}, 1'b1,
        result_t'{ST_ACCEPTED, 16'd0, 1'b0, 8'd0, 7'd7, 1'b1}},
      '{item_t'{CMD_SIGNAL, 16'h0000, 1'b0}, 1'b0, '0},
      '{item_t'{CMD_ARRIVAL, 16'h0080, 1'b0}, 1'b1,
        result_t'{ST_ACCEPTED, 16'd0, 1'b0, 8'd0, 7'd4, 1'b1}},
      '{item_t'{CMD_ARRIVAL, 16'h0100, 1'b1}, 1'b1,
        result_t'{ST_ACCEPTED, 16'd0, 1'b0, 8'd0, 7'd5, 1'b1}},
      '{item_t'{CMD_ARRIVAL, 16'h0200, 1'b0}, 1'b1,
        result_t'{ST_ACCEPTED, 16'd0, 1'b0, 8'd0, 7'd6, 1'b1}},
      '{item_t'{CMD_ARRIVAL, 16'h0400, 1'b1}, 1'b1,
        result_t'{ST_ACCEPTED, 16'd0, 1'b0, 8'd0, 7'd7, 1'b1}},
      '{item_t'{CMD_ARRIVAL, 16'h0800, 1'b0}, 1'b1,
        result_t'{ST_ACCEPTED, 16'd0, 1'b0, 8'd0, 7'd8, 1'b1}},
      '{item_t'{CMD_ARRIVAL, 16'h1000, 1'b0}, 1'b1,
        result_t'{ST_ACCEPTED, 16'd0, 1'b0, 8'd0, 7'd9, 1'b1}},
      '{item_t'{CMD_ARRIVAL, 16'h2000, 1'b1}, 1'b1,
        result_t'{ST_ACCEPTED, 16'd0, 1'b0, 8'd0, 7'd10, 1'b1}},
      '{item_t'{CMD_ARRIVAL, 16'h4000, 1'b0}, 1'b1,
        result_t'{ST_ACCEPTED, 16'd0, 1'b0, 8'd0, 7'd11, 1'b1}},
      '{item_t'{CMD_SIGNAL, 16'hFFFF, 1'b1}, 1'b0, '0}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_plan[i]) begin
      send_item(directed_plan[i].it, directed_plan[i].typed, directed_plan[i].want);
      idle_gap();
    end

    for (seg = 0; seg < SEGMENTS; seg++) begin
      // registers only change with nothing in flight
      drain_results();
      case (seg)
        1: begin
          // every nonempty signal releases the maximum
          write_cfg(CFG_HIGH_THR, 8'd0);
          write_cfg(CFG_MID_THR, 8'd0);
          write_cfg(CFG_GREEN_LONG, 8'd250);
          write_cfg(CFG_GREEN_MID, 8'd250);
          write_cfg(CFG_GREEN_SHORT, 8'd250);
        end
        2: begin
          // thresholds masked to 127, only the short green is reachable
          write_cfg(CFG_HIGH_THR, 8'hFF);
          write_cfg(CFG_MID_THR, 8'd64);
          write_cfg(CFG_GREEN_LONG, 8'd0);
          write_cfg(CFG_GREEN_MID, 8'd9);
          write_cfg(CFG_GREEN_SHORT, 8'hFF);
        end
        3: begin
          write_cfg(CFG_HIGH_THR, 8'd63);
          write_cfg(CFG_MID_THR, 8'd30);
          write_cfg(CFG_GREEN_LONG, 8'd250);
          write_cfg(CFG_GREEN_MID, 8'd9);
          write_cfg(CFG_GREEN_SHORT, 8'd0);
        end
        4, 5: begin
          write_cfg(CFG_HIGH_THR, 8'($urandom_range(0, 127)));
          write_cfg(CFG_MID_THR, 8'($urandom_range(0, 127)));
          write_cfg(CFG_GREEN_LONG, 8'($urandom));
          write_cfg(CFG_GREEN_MID, 8'($urandom));
          write_cfg(CFG_GREEN_SHORT, 8'($urandom));
          // indexes past the last register must not disturb anything
          for (int k = 1; k <= 3; k++)
            write_cfg(CFG_IDX_W'(CFG_GREEN_SHORT + k), 8'($urandom));
        end
        default: ;
      endcase
      idle_pct = (seg < 2) ? 16 : (seg < 4) ? 78 : 0;
      sent = 0;
      if (seg % 2 == 1) begin
        // fill the ring to full and push a few arrivals into the drop case
        burst = 0;
        while (burst < 3) begin
          if (occ_mirror >= DEPTH) burst++;
          send_item(rand_item(CMD_ARRIVAL), 1'b0, none);
          idle_gap();
          sent++;
        end
      end
      while (sent < SEG_ITEMS) begin
        if ($urandom_range(0, 99) < 30) begin
          send_item(rand_item(CMD_SIGNAL), 1'b0, none);
          idle_gap();
          sent++;
        end else begin
          repeat ($urandom_range(1, 6)) begin
            send_item(rand_item(CMD_ARRIVAL), 1'b0, none);
            idle_gap();
            sent++;
          end
        end
      end
    end

    drain_results();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
